/* hw/rtl/pgcas_pkg.sv */
// pgcas_pkg: shared types, codes and constants of the card access sequencer
// used by the channel interfaces, the sequencer top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package pgcas_pkg;

    // uid storage
    localparam int UID_BYTES = 7;
    localparam int UID_W     = 56;
    localparam int ULEN_W    = 3;

    // tick counters and the width their limits are compared at
    localparam int TICK_BITS = 16;
    localparam int LIMIT_W   = 16;
    localparam int CMP_W     = (TICK_BITS > LIMIT_W) ? TICK_BITS : LIMIT_W;

    // input and configuration field widths
    localparam int DIST_W    = 10;
    localparam int CM_W      = 9;
    localparam int TALLY_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // result field widths
    localparam int MODE_W    = 4;
    localparam int LED_W     = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE     = 4'd0,
        MODE_ON       = 4'd1,
        MODE_WAIT_PRS = 4'd2,
        MODE_PRESENCE = 4'd3,
        MODE_WAIT_CRD = 4'd4,
        MODE_ENROLL   = 4'd5,
        MODE_VERIFY   = 4'd6,
        MODE_SUCCESS  = 4'd7,
        MODE_FAIL     = 4'd8,
        MODE_COOLDOWN = 4'd9
    } mode_t;

    typedef enum logic [LED_W-1:0] {
        LED_IDLE     = 3'd0,
        LED_WAIT_PRS = 3'd1,
        LED_WAIT_CRD = 3'd2,
        LED_OK       = 3'd3,
        LED_BAD      = 3'd4
    } led_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_WINDOW = 3'd0,
        CFG_CLEAR_PRESS  = 3'd1,
        CFG_MIN_DIST     = 3'd2,
        CFG_MAX_DIST     = 3'd3,
        CFG_PRESENCE     = 3'd4,
        CFG_COOLDOWN     = 3'd5
    } cfg_idx_t;

    // mask keeping the low n bytes of a uid word
    function automatic logic [UID_W-1:0] byte_mask(input logic [ULEN_W-1:0] n);
        logic [UID_W-1:0] m;
        m = '0;
        for (int b = 0; b < UID_W / 8; b++)
        begin
            if (b < int'(n))
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pgcas_if.sv */
// pgcas_if: valid/ready channel interfaces for tick words, result words and
// configuration writes; depends on pgcas_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pgcas_tick_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   button_pressed;
    logic signed [pgcas_pkg::DIST_W-1:0]    distance;
    logic                                   card_present;
    logic        [pgcas_pkg::ULEN_W-1:0]    uid_length;
    logic        [pgcas_pkg::UID_W-1:0]     uid_value;

    modport source (output valid, button_pressed, distance, card_present,
                    uid_length, uid_value, input ready);
    modport sink   (input valid, button_pressed, distance, card_present,
                    uid_length, uid_value, output ready);
endinterface

interface pgcas_result_if;
    logic                           valid;
    logic                           ready;
    logic [pgcas_pkg::MODE_W-1:0]   mode;
    logic [pgcas_pkg::LED_W-1:0]    led_pattern;
    logic                           card_enrolled;
    logic                           enabled;
    logic                           storage_cleared;

    modport source (output valid, mode, led_pattern, card_enrolled, enabled,
                    storage_cleared, input ready);
    modport sink   (input valid, mode, led_pattern, card_enrolled, enabled,
                    storage_cleared, output ready);
endinterface

interface pgcas_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pgcas_pkg::CFG_IDX_W-1:0]    index;
    logic [pgcas_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/presence_gated_card_access_sequencer.sv */
// Presence-gated card access sequencer: channel usage and timing
//   tick   : one word per loop tick (button press, distance, card read)
//   result : one word per tick (mode, led pattern, enrolled, enabled, cleared)
//   cfg    : register writes (index, data), always ready, taken at once;
//            write only while no tick word is in flight
// Path: an accepted tick word sits in the input register, and its result is then
// loaded into the result register, valid from then on.
// Throughput: one tick word per cycle unless stalled; the mode, timers, press
// run and uid compare all settle in one pass of logic between the input
// and result registers; the sequencer state updates as the result is loaded.
// Stalls: while result.ready is low the result word holds; one more tick word
// may wait in the input register, then tick.ready drops until the result
// drains.
// Reset: asynchronous, rst_n low; mode idle, switched off, nothing enrolled,
// timers and press run cleared, registers back to their defaults
// (window 200, clear presses 5, band 2..30 cm, wait 500, cooldown 300).
// Enrolled and captured uid storage is not cleared and is read only after
// it has been written.
`timescale 1ns / 1ps
`default_nettype none

module presence_gated_card_access_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    pgcas_tick_if.sink          tick,
    pgcas_result_if.source      result,
    pgcas_cfg_if.sink           cfg
);

    // configuration registers
    logic [pgcas_pkg::LIMIT_W-1:0]  press_window_reg;
    logic [pgcas_pkg::TALLY_W-1:0]  clear_press_reg;
    logic [pgcas_pkg::CM_W-1:0]     min_dist_reg;
    logic [pgcas_pkg::CM_W-1:0]     max_dist_reg;
    logic [pgcas_pkg::LIMIT_W-1:0]  presence_wait_reg;
    logic [pgcas_pkg::LIMIT_W-1:0]  cooldown_reg;

    // input register
    logic                                   in_valid_reg;
    logic                                   in_btn_reg;
    logic signed [pgcas_pkg::DIST_W-1:0]    in_dist_reg;
    logic                                   in_card_reg;
    logic        [pgcas_pkg::ULEN_W-1:0]    in_len_reg;
    logic        [pgcas_pkg::UID_W-1:0]     in_uid_reg;

    // sequencer state
    pgcas_pkg::mode_t                   mode_reg, mode_next;
    pgcas_pkg::led_t                    led_reg, led_next;
    logic                               enabled_reg, enabled_next;
    logic                               enr_valid_reg, enr_valid_next;
    logic [pgcas_pkg::UID_W-1:0]        enr_uid_reg, enr_uid_next;
    logic [pgcas_pkg::ULEN_W-1:0]       enr_len_reg, enr_len_next;
    logic [pgcas_pkg::UID_W-1:0]        cap_uid_reg, cap_uid_next;
    logic [pgcas_pkg::ULEN_W-1:0]       cap_len_reg, cap_len_next;
    logic [pgcas_pkg::TICK_BITS-1:0]    mode_ticks_reg, mode_ticks_next;
    logic [pgcas_pkg::TICK_BITS-1:0]    press_ticks_reg, press_ticks_next;
    logic [pgcas_pkg::TALLY_W-1:0]      tally_reg, tally_next;
    logic                               cleared_next;

    // result register
    logic                               out_valid_reg;
    logic [pgcas_pkg::MODE_W-1:0]       out_mode_reg;
    logic [pgcas_pkg::LED_W-1:0]        out_led_reg;
    logic                               out_enrolled_reg;
    logic                               out_enabled_reg;
    logic                               out_cleared_reg;

    logic                               advance;

    // handshake: a word moves from the input register into the result register
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    // configuration write decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_window_reg  <= pgcas_pkg::LIMIT_W'(200);
            clear_press_reg   <= pgcas_pkg::TALLY_W'(5);
            min_dist_reg      <= pgcas_pkg::CM_W'(2);
            max_dist_reg      <= pgcas_pkg::CM_W'(30);
            presence_wait_reg <= pgcas_pkg::LIMIT_W'(500);
            cooldown_reg      <= pgcas_pkg::LIMIT_W'(300);
        end
        else if (cfg.valid)
        begin
            unique case (pgcas_pkg::cfg_idx_t'(cfg.index))
                pgcas_pkg::CFG_PRESS_WINDOW: press_window_reg  <= cfg.data;
                pgcas_pkg::CFG_CLEAR_PRESS:  clear_press_reg   <= cfg.data[pgcas_pkg::TALLY_W-1:0];
                pgcas_pkg::CFG_MIN_DIST:     min_dist_reg      <= cfg.data[pgcas_pkg::CM_W-1:0];
                pgcas_pkg::CFG_MAX_DIST:     max_dist_reg      <= cfg.data[pgcas_pkg::CM_W-1:0];
                pgcas_pkg::CFG_PRESENCE:     presence_wait_reg <= cfg.data;
                pgcas_pkg::CFG_COOLDOWN:     cooldown_reg      <= cfg.data;
                default:                     ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_btn_reg  <= tick.button_pressed;
            in_dist_reg <= tick.distance;
            in_card_reg <= tick.card_present;
            in_len_reg  <= tick.uid_length;
            in_uid_reg  <= tick.uid_value;
        end
    end

    // next sequencer state for the word in the input register
    always_comb
    begin
        logic [pgcas_pkg::TICK_BITS-1:0]    mt_inc;
        logic [pgcas_pkg::TICK_BITS-1:0]    pt_inc;
        logic                               in_band;
        logic [pgcas_pkg::UID_W-1:0]        uid_v;
        logic [pgcas_pkg::ULEN_W-1:0]       uid_n;
        logic [5:0]                         uid_shift;

        mt_inc = (mode_ticks_reg == '1) ? mode_ticks_reg : mode_ticks_reg + 1'b1;
        pt_inc = (press_ticks_reg == '1) ? press_ticks_reg : press_ticks_reg + 1'b1;

        // presence band, negative distance never counts
        in_band = !in_dist_reg[pgcas_pkg::DIST_W-1]
                  && (in_dist_reg[pgcas_pkg::CM_W-1:0] >= min_dist_reg)
                  && (in_dist_reg[pgcas_pkg::CM_W-1:0] <= max_dist_reg);

        // captured uid, long reads keep their leading bytes
        uid_v     = in_uid_reg & pgcas_pkg::byte_mask(in_len_reg);
        uid_n     = in_len_reg;
        uid_shift = '0;
        if (int'(in_len_reg) > pgcas_pkg::UID_BYTES)
        begin
            uid_shift = 6'((int'(in_len_reg) - pgcas_pkg::UID_BYTES) * 8);
            uid_n     = pgcas_pkg::ULEN_W'(pgcas_pkg::UID_BYTES);
        end
        uid_v = (uid_v >> uid_shift) & pgcas_pkg::byte_mask(uid_n);

        mode_next        = mode_reg;
        led_next         = led_reg;
        enabled_next     = enabled_reg;
        enr_valid_next   = enr_valid_reg;
        enr_uid_next     = enr_uid_reg;
        enr_len_next     = enr_len_reg;
        cap_uid_next     = cap_uid_reg;
        cap_len_next     = cap_len_reg;
        mode_ticks_next  = mt_inc;
        press_ticks_next = pt_inc;
        tally_next       = tally_reg;
        cleared_next     = 1'b0;

        if (in_btn_reg)
        begin
            // press run counting
            if (tally_reg == '0
                || pgcas_pkg::CMP_W'(pt_inc) > pgcas_pkg::CMP_W'(press_window_reg))
            begin
                tally_next       = pgcas_pkg::TALLY_W'(1);
                press_ticks_next = '0;
            end
            else
            begin
                tally_next = tally_reg + 1'b1;
            end

            mode_ticks_next = '0;
            cap_len_next    = '0;
            if (tally_next >= clear_press_reg)
            begin
                // press run complete: forget the card and switch off
                tally_next       = '0;
                press_ticks_next = '0;
                enr_valid_next   = 1'b0;
                enabled_next     = 1'b0;
                led_next         = pgcas_pkg::LED_IDLE;
                mode_next        = pgcas_pkg::MODE_IDLE;
                cleared_next     = 1'b1;
            end
            else if (mode_reg == pgcas_pkg::MODE_IDLE)
            begin
                enabled_next = 1'b1;
                led_next     = pgcas_pkg::LED_WAIT_PRS;
                mode_next    = pgcas_pkg::MODE_ON;
            end
            else
            begin
                enabled_next = 1'b0;
                led_next     = pgcas_pkg::LED_IDLE;
                mode_next    = pgcas_pkg::MODE_IDLE;
            end
        end
        else
        begin
            unique case (mode_reg)
                pgcas_pkg::MODE_ON:
                begin
                    mode_next       = pgcas_pkg::MODE_WAIT_PRS;
                    mode_ticks_next = '0;
                end
                pgcas_pkg::MODE_WAIT_PRS:
                begin
                    if (in_band)
                    begin
                        led_next        = pgcas_pkg::LED_WAIT_CRD;
                        mode_next       = pgcas_pkg::MODE_PRESENCE;
                        mode_ticks_next = '0;
                    end
                    else if (pgcas_pkg::CMP_W'(mt_inc)
                             >= pgcas_pkg::CMP_W'(presence_wait_reg))
                    begin
                        led_next        = pgcas_pkg::LED_BAD;
                        mode_next       = pgcas_pkg::MODE_COOLDOWN;
                        mode_ticks_next = '0;
                    end
                end
                pgcas_pkg::MODE_PRESENCE:
                begin
                    mode_next       = pgcas_pkg::MODE_WAIT_CRD;
                    mode_ticks_next = '0;
                end
                pgcas_pkg::MODE_WAIT_CRD:
                begin
                    if (in_card_reg && in_len_reg != '0)
                    begin
                        cap_uid_next    = uid_v;
                        cap_len_next    = uid_n;
                        mode_next       = enr_valid_reg ? pgcas_pkg::MODE_VERIFY
                                                        : pgcas_pkg::MODE_ENROLL;
                        mode_ticks_next = '0;
                    end
                end
                pgcas_pkg::MODE_ENROLL:
                begin
                    enr_uid_next    = cap_uid_reg;
                    enr_len_next    = cap_len_reg;
                    enr_valid_next  = 1'b1;
                    mode_next       = pgcas_pkg::MODE_VERIFY;
                    mode_ticks_next = '0;
                end
                pgcas_pkg::MODE_VERIFY:
                begin
                    cap_len_next    = '0;
                    mode_ticks_next = '0;
                    if (enr_valid_reg && enr_len_reg == cap_len_reg
                        && enr_uid_reg == cap_uid_reg)
                    begin
                        led_next  = pgcas_pkg::LED_OK;
                        mode_next = pgcas_pkg::MODE_SUCCESS;
                    end
                    else
                    begin
                        led_next  = pgcas_pkg::LED_BAD;
                        mode_next = pgcas_pkg::MODE_FAIL;
                    end
                end
                pgcas_pkg::MODE_COOLDOWN:
                begin
                    if (pgcas_pkg::CMP_W'(mt_inc) >= pgcas_pkg::CMP_W'(cooldown_reg))
                    begin
                        mode_ticks_next = '0;
                        if (!enabled_reg)
                        begin
                            cap_len_next = '0;
                            led_next     = pgcas_pkg::LED_IDLE;
                            mode_next    = pgcas_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            led_next  = pgcas_pkg::LED_WAIT_PRS;
                            mode_next = pgcas_pkg::MODE_WAIT_PRS;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= pgcas_pkg::MODE_IDLE;
            led_reg         <= pgcas_pkg::LED_IDLE;
            enabled_reg     <= 1'b0;
            enr_valid_reg   <= 1'b0;
            cap_len_reg     <= '0;
            mode_ticks_reg  <= '0;
            press_ticks_reg <= '0;
            tally_reg       <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            led_reg         <= led_next;
            enabled_reg     <= enabled_next;
            enr_valid_reg   <= enr_valid_next;
            cap_len_reg     <= cap_len_next;
            mode_ticks_reg  <= mode_ticks_next;
            press_ticks_reg <= press_ticks_next;
            tally_reg       <= tally_next;
        end
    end

    // uid storage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            enr_uid_reg <= enr_uid_next;
            enr_len_reg <= enr_len_next;
            cap_uid_reg <= cap_uid_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mode_reg     <= mode_next;
            out_led_reg      <= led_next;
            out_enrolled_reg <= enr_valid_next;
            out_enabled_reg  <= enabled_next;
            out_cleared_reg  <= cleared_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.mode            = out_mode_reg;
    assign result.led_pattern     = out_led_reg;
    assign result.card_enrolled   = out_enrolled_reg;
    assign result.enabled         = out_enabled_reg;
    assign result.storage_cleared = out_cleared_reg;

endmodule

`default_nettype wire

/* hw/rtl/pgcas_checker.sv */
// pgcas_checker: port-level checks on the card access sequencer's result word
// depends on pgcas_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module pgcas_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           tick_valid,
    input  wire logic                           tick_ready,
    input  wire logic                           result_valid,
    input  wire logic                           result_ready,
    input  wire logic [pgcas_pkg::MODE_W-1:0]   mode,
    input  wire logic [pgcas_pkg::LED_W-1:0]    led_pattern,
    input  wire logic                           card_enrolled,
    input  wire logic                           enabled,
    input  wire logic                           storage_cleared,
    input  wire logic                           cfg_valid
);

    // a stalled result word stays valid
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    // a press-run clear leaves the block off, idle and with no card
    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && storage_cleared |->
            mode == pgcas_pkg::MODE_IDLE && !enabled
            && !card_enrolled && led_pattern == pgcas_pkg::LED_IDLE)
        else $error("clear pulse without idle state");

    // switched off means idle mode with the idle pattern
    a_off_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !enabled |->
            mode == pgcas_pkg::MODE_IDLE
            && led_pattern == pgcas_pkg::LED_IDLE)
        else $error("disabled block outside idle");

    // success needs an enrolled card and the block on, and shows the success pattern
    a_success_led: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && mode == pgcas_pkg::MODE_SUCCESS |->
            card_enrolled && enabled
            && led_pattern == pgcas_pkg::LED_OK)
        else $error("success without enrolled card or success pattern");

    // the input side keeps flowing: tick_ready is high whenever no result waits and no cfg write is offered
    a_tick_flows: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !cfg_valid |-> tick_ready)
        else $error("tick channel stalled with empty result slot");

    // tick_valid is used by no check above; here it must be known while tick_ready is high
    a_tick_known: assert property (@(posedge clk) disable iff (!rst_n)
        tick_ready |-> !$isunknown(tick_valid))
        else $error("tick valid unknown while ready");

endmodule

bind presence_gated_card_access_sequencer pgcas_checker u_pgcas_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick_valid      (tick.valid),
    .tick_ready      (tick.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .mode            (result.mode),
    .led_pattern     (result.led_pattern),
    .card_enrolled   (result.card_enrolled),
    .enabled         (result.enabled),
    .storage_cleared (result.storage_cleared),
    .cfg_valid       (cfg.valid)
);

`default_nettype wire
